// ===== hw/rtl/fmbs_pkg.sv =====
package fmbs_pkg;

    // Fixed field widths of the transaction ports.
    localparam int OP_W  = 2;
    localparam int SYM_W = 8;
    localparam int ROW_W = 13;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_STEP  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic store_write;
        logic hist_inc;
        logic set_empty;
        logic count_latch;
        logic c_init;
        logic c_run;
        logic fresh;
        logic occ_init;
        logic occ_run;
        logic occ_finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic load_ok;
        logic sym_nonzero;
        logic sym_ok;
        logic count_zero;
        logic cur_empty;
        logic crossed;
        logic c_done;
        logic occ_done;
    } status_t;

endpackage

// ===== hw/rtl/fmbs_dp.sv =====
module fmbs_dp
    import fmbs_pkg::*;
#(
    parameter int MAX_TEXT      = 4096,
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [OP_W-1:0]  op,
    input  logic [SYM_W-1:0] symbol,
    input  cmd_t             cmd,
    output status_t          stat,
    output logic [ROW_W-1:0] first_row,
    output logic [ROW_W-1:0] last_row,
    output logic             range_is_empty
);

    localparam int KW = $clog2(MAX_TEXT + 1);
    localparam int LW = $clog2(MAX_TEXT);
    localparam int RW = $clog2(MAX_TEXT + 3);
    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam logic [KW-1:0]  MAX_LEN   = KW'(MAX_TEXT);
    localparam logic [SYM_W:0] ALPHA_LIM = (SYM_W + 1)'(ALPHABET_SIZE);

    op_t              op_reg;
    logic [SYM_W-1:0] sym_reg;

    logic [SYM_W-1:0] store_mem [MAX_TEXT];
    logic [SYM_W-1:0] store_rdata_reg;

    logic [KW-1:0]    hist_mem [ALPHABET_SIZE];
    logic             hist_valid_reg [ALPHABET_SIZE];
    logic [KW-1:0]    hist_rdata_reg;
    logic             hist_rvalid_reg;

    logic [KW-1:0]    len_reg;
    logic [RW-1:0]    cur_first_reg;
    logic [RW-1:0]    cur_last_reg;
    logic             cur_empty_reg;
    logic [KW-1:0]    count_reg;

    logic [AW-1:0]    s_reg;
    logic             c_pend_reg;
    logic [RW-1:0]    base_reg;

    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    n_reg;
    logic             o_pend_reg;
    logic             o_inf_reg;
    logic [KW-1:0]    occ_f_reg;
    logic [KW-1:0]    occ_l_reg;

    logic [KW-1:0]    hist_eff;
    logic [AW-1:0]    sym_idx;
    logic [AW-1:0]    hist_addr;
    logic             c_more;
    logic             occ_more;
    logic [RW-1:0]    last_cap;
    logic [RW-1:0]    nf;
    logic [RW-1:0]    nl;
    logic             sym_in_range;

    assign sym_idx      = sym_reg[AW-1:0];
    assign hist_eff     = hist_rvalid_reg ? hist_rdata_reg : '0;
    assign hist_addr    = cmd.c_run ? s_reg : sym_idx;
    assign c_more       = s_reg < sym_idx;
    assign occ_more     = k_reg < n_reg;
    assign sym_in_range = {1'b0, sym_reg} < ALPHA_LIM;
    assign last_cap     = (cur_last_reg < RW'(len_reg)) ? cur_last_reg : RW'(len_reg);
    assign nf           = base_reg + RW'(1) + RW'(occ_f_reg);
    assign nl           = base_reg + RW'(occ_l_reg);

    // Store and histogram arrays: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.store_write)
        begin
            store_mem[len_reg[LW-1:0]] <= sym_reg;
        end
        if (cmd.occ_run && occ_more)
        begin
            store_rdata_reg <= store_mem[k_reg[LW-1:0]];
        end
        if (cmd.hist_inc)
        begin
            hist_mem[sym_idx] <= hist_eff + KW'(1);
        end
        hist_rdata_reg <= hist_mem[hist_addr];
        if (cmd.capture)
        begin
            sym_reg <= symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= OP_NOP;
            hist_valid_reg  <= '{default: 1'b0};
            hist_rvalid_reg <= 1'b0;
            len_reg         <= '0;
            cur_first_reg   <= '0;
            cur_last_reg    <= '0;
            cur_empty_reg   <= 1'b1;
            count_reg       <= '0;
            s_reg           <= '0;
            c_pend_reg      <= 1'b0;
            base_reg        <= '0;
            k_reg           <= '0;
            n_reg           <= '0;
            o_pend_reg      <= 1'b0;
            o_inf_reg       <= 1'b0;
            occ_f_reg       <= '0;
            occ_l_reg       <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                op_reg <= op_t'(op);
            end
            hist_rvalid_reg <= hist_valid_reg[hist_addr];
            if (cmd.hist_inc)
            begin
                hist_valid_reg[sym_idx] <= 1'b1;
            end
            if (cmd.store_write)
            begin
                len_reg <= len_reg + KW'(1);
            end
            if (cmd.count_latch)
            begin
                count_reg <= hist_eff;
            end

            // C value: walk histogram entries 1 .. c-1, one read per cycle.
            if (cmd.c_init)
            begin
                s_reg      <= AW'(1);
                c_pend_reg <= 1'b0;
                base_reg   <= RW'(1);
            end
            else if (cmd.c_run)
            begin
                if (c_more)
                begin
                    s_reg      <= s_reg + AW'(1);
                    c_pend_reg <= 1'b1;
                end
                else
                begin
                    c_pend_reg <= 1'b0;
                end
                if (c_pend_reg)
                begin
                    base_reg <= base_reg + RW'(hist_eff);
                end
            end

            // Occurrence counts for both range ends in one pass over the store.
            if (cmd.occ_init)
            begin
                k_reg      <= '0;
                n_reg      <= KW'(last_cap);
                o_pend_reg <= 1'b0;
                occ_f_reg  <= '0;
                occ_l_reg  <= '0;
            end
            else if (cmd.occ_run)
            begin
                if (occ_more)
                begin
                    k_reg      <= k_reg + KW'(1);
                    o_pend_reg <= 1'b1;
                    o_inf_reg  <= (RW'(k_reg) + RW'(1)) < cur_first_reg;
                end
                else
                begin
                    o_pend_reg <= 1'b0;
                end
                if (o_pend_reg && (store_rdata_reg == sym_reg))
                begin
                    occ_l_reg <= occ_l_reg + KW'(1);
                    if (o_inf_reg)
                    begin
                        occ_f_reg <= occ_f_reg + KW'(1);
                    end
                end
            end

            if (cmd.set_empty || (cmd.occ_finish && (nl < nf)))
            begin
                cur_first_reg <= '0;
                cur_last_reg  <= '0;
                cur_empty_reg <= 1'b1;
            end
            else if (cmd.fresh)
            begin
                cur_first_reg <= base_reg + RW'(1);
                cur_last_reg  <= base_reg + RW'(count_reg);
                cur_empty_reg <= 1'b0;
            end
            else if (cmd.occ_finish)
            begin
                cur_first_reg <= nf;
                cur_last_reg  <= nl;
                cur_empty_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.load_ok     = (len_reg < MAX_LEN) && sym_in_range;
        stat.sym_nonzero = sym_reg != '0;
        stat.sym_ok      = (sym_reg != '0) && sym_in_range;
        stat.count_zero  = hist_eff == '0;
        stat.cur_empty   = cur_empty_reg;
        stat.crossed     = (cur_last_reg < cur_first_reg) || (cur_first_reg == '0);
        stat.c_done      = !c_more && !c_pend_reg;
        stat.occ_done    = !occ_more && !o_pend_reg;
    end

    // An empty range always holds zero rows, so the registers drive the ports.
    assign first_row      = ROW_W'(cur_first_reg);
    assign last_row       = ROW_W'(cur_last_reg);
    assign range_is_empty = cur_empty_reg;

endmodule

// ===== hw/rtl/fmbs_ctrl.sv =====
module fmbs_ctrl
    import fmbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t stat,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HIST_INC,
        S_COUNT,
        S_C_SWEEP,
        S_OCC_SWEEP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   count_stop;

    assign count_stop = stat.count_zero || (!stat.cur_empty && stat.crossed);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_LOAD:  cmd.store_write = stat.load_ok;
                    OP_CLEAR: cmd.set_empty = 1'b1;
                    OP_STEP:  cmd.set_empty = !stat.sym_ok;
                    OP_NOP:   cmd.set_empty = 1'b0;
                    default:  cmd.set_empty = 1'b0;
                endcase
            end
            S_HIST_INC:
            begin
                cmd.hist_inc = 1'b1;
            end
            S_COUNT:
            begin
                cmd.count_latch = 1'b1;
                cmd.set_empty   = count_stop;
                cmd.c_init      = !count_stop;
            end
            S_C_SWEEP:
            begin
                cmd.c_run    = 1'b1;
                cmd.fresh    = stat.c_done && stat.cur_empty;
                cmd.occ_init = stat.c_done && !stat.cur_empty;
            end
            S_OCC_SWEEP:
            begin
                cmd.occ_run    = 1'b1;
                cmd.occ_finish = stat.occ_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DECODE;
                        busy_reg  <= 1'b1;
                    end
                end
                S_DECODE:
                begin
                    if (stat.op == OP_LOAD && stat.load_ok && stat.sym_nonzero)
                    begin
                        state_reg <= S_HIST_INC;
                    end
                    else if (stat.op == OP_STEP && stat.sym_ok)
                    begin
                        state_reg <= S_COUNT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                S_HIST_INC:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                S_COUNT:
                begin
                    if (count_stop)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_C_SWEEP;
                    end
                end
                S_C_SWEEP:
                begin
                    if (stat.c_done)
                    begin
                        if (stat.cur_empty)
                        begin
                            state_reg <= S_IDLE;
                            busy_reg  <= 1'b0;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_OCC_SWEEP;
                        end
                    end
                end
                S_OCC_SWEEP:
                begin
                    if (stat.occ_done)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/fm_index_backward_search.sv =====
// FM-index backward search engine.
// A transaction is taken at a rising clock edge where start is high and busy
// is low; op and symbol are sampled at that edge. Op 0 appends a BWT symbol
// to the store, op 1 clears the search range, op 2 narrows the range with one
// pattern character (pattern fed from its last character to its first).
// Every transaction produces exactly one result: done is high for one cycle
// while first_row, last_row and range_is_empty show the range after it.
// The receiver cannot stall; the result is simply presented for that cycle.
// Busy stays high from the accepting edge until done, and the next
// transaction may be taken in the done cycle, so transactions follow one
// another at the latency. A step from an empty range walks the histogram
// entries below the symbol code c; a narrowing step then also walks the
// store up to n, the smaller of the last row and the stored length.
// Reset clears the histogram (through per-entry valid bits, so at once), the
// stored length and the range, which becomes empty. The store itself is not
// cleared; entries past the stored length are never counted.
module fm_index_backward_search
    import fmbs_pkg::*;
#(
    parameter int MAX_TEXT      = 4096,
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  op,
    input  logic [SYM_W-1:0] symbol,
    output logic             done,
    output logic [ROW_W-1:0] first_row,
    output logic [ROW_W-1:0] last_row,
    output logic             range_is_empty
);

    cmd_t    cmd;
    status_t stat;

    // The controller sequences each transaction; the datapath holds the
    // store, the histogram, the sweep counters and the current range.
    fmbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fmbs_dp #(
        .MAX_TEXT      (MAX_TEXT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .symbol         (symbol),
        .cmd            (cmd),
        .stat           (stat),
        .first_row      (first_row),
        .last_row       (last_row),
        .range_is_empty (range_is_empty)
    );

    // An accepted transaction always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result only ends work that was in progress, and it frees the block.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    // An empty range always reports zero rows.
    a_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
        range_is_empty |-> (first_row == '0 && last_row == '0))
        else $error("empty range reports nonzero rows");

endmodule

// ===== test/fm_index_backward_search_checker.sv =====
`timescale 1ns / 100ps

module fm_index_backward_search_checker
    import fmbs_pkg::*;
#(
    parameter int MAX_TEXT      = 4096,
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [OP_W-1:0]  op,
    input  logic [SYM_W-1:0] symbol,
    input  logic             done,
    input  logic [ROW_W-1:0] first_row,
    input  logic [ROW_W-1:0] last_row,
    input  logic             range_is_empty,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [ROW_W-1:0] first;
        logic [ROW_W-1:0] last;
        logic             empty;
    } row_range_t;

    // Shadow copy of the index: the BWT text, the per-symbol tallies and
    // the current search range.
    logic [SYM_W-1:0] bwt_shadow [MAX_TEXT];
    int unsigned      sym_tally [ALPHABET_SIZE];
    int unsigned      text_len;
    int unsigned      range_first;
    int unsigned      range_last;
    bit               range_empty;

    row_range_t       expected_ranges [$];

    // Row offset of the block of rows that start with symbol c.
    function automatic int unsigned c_offset(input int unsigned c);
        int unsigned total;
        total = 1;
        for (int unsigned s = 1; s < c && s < ALPHABET_SIZE; s++)
            total += sym_tally[s];
        return total;
    endfunction

    // Occurrences of c in BWT positions 1..upto, never past the loaded text.
    function automatic int unsigned occ_upto(input int unsigned c, input int unsigned upto);
        int unsigned n;
        int unsigned hits;
        n    = (upto < text_len) ? upto : text_len;
        hits = 0;
        for (int unsigned k = 0; k < n; k++)
            if (bwt_shadow[k] == c)
                hits++;
        return hits;
    endfunction

    function automatic void empty_range();
        range_first = 0;
        range_last  = 0;
        range_empty = 1'b1;
    endfunction

    function automatic void narrow_range(input int unsigned c);
        int unsigned base;
        int unsigned nf;
        int unsigned nl;
        if (c == 0 || c >= ALPHABET_SIZE || sym_tally[c] == 0)
        begin
            empty_range();
            return;
        end
        base = c_offset(c);
        if (range_empty)
        begin
            range_first = base + 1;
            range_last  = base + sym_tally[c];
            range_empty = 1'b0;
            return;
        end
        if (range_last < range_first || range_first == 0)
        begin
            empty_range();
            return;
        end
        nf = base + 1 + occ_upto(c, range_first - 1);
        nl = base + occ_upto(c, range_last);
        if (nl < nf)
        begin
            empty_range();
            return;
        end
        range_first = nf;
        range_last  = nl;
    endfunction

    // Updates the shadow index with one transaction and returns the range it reports.
    function automatic row_range_t apply_transaction(input op_t o, input logic [SYM_W-1:0] s);
        row_range_t r;
        case (o)
            OP_LOAD:
            begin
                if (text_len < MAX_TEXT && s < ALPHABET_SIZE)
                begin
                    bwt_shadow[text_len] = s;
                    text_len++;
                    if (s != 0)
                        sym_tally[s]++;
                end
            end
            OP_CLEAR: empty_range();
            OP_STEP:  narrow_range(s);
            default:  ;
        endcase
        r.first = range_empty ? '0 : range_first[ROW_W-1:0];
        r.last  = range_empty ? '0 : range_last[ROW_W-1:0];
        r.empty = range_empty;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input logic [ROW_W-1:0] got);
        if (got !== want[ROW_W-1:0])
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Everything is sampled at the falling edge, half a cycle away from the
    // rising edge where the block and the stimulus change their signals.
    // While reset is low the shadow index returns to its reset state.
    // The result of an older transaction is matched before a transaction
    // accepted at the same edge is queued.
    always @(negedge clk)
    begin
        row_range_t want;
        if (!rst_n)
        begin
            fail_count  = 0;
            pending     = 0;
            text_len    = 0;
            range_first = 0;
            range_last  = 0;
            range_empty = 1'b1;
            foreach (sym_tally[i])
                sym_tally[i] = 0;
            expected_ranges.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $display("%0t: result with no transaction outstanding, actual %0d %0d %0d",
                             $time, first_row, last_row, range_is_empty);
                    fail_count++;
                end
                else
                begin
                    want = expected_ranges.pop_front();
                    compare_field("first_row", 32'(want.first), first_row);
                    compare_field("last_row", 32'(want.last), last_row);
                    compare_field("range_is_empty", 32'(want.empty),
                                  ROW_W'(range_is_empty));
                end
            end
            if (start && !busy)
                expected_ranges.insert(expected_ranges.size(),
                                       apply_transaction(op_t'(op), symbol));
            pending = expected_ranges.size();
        end
    end

endmodule

// ===== test/fm_index_backward_search_tb.sv =====
`timescale 1ns / 100ps

module fm_index_backward_search_tb;
    import fmbs_pkg::*;

    localparam int MAX_TEXT      = 4096;
    localparam int ALPHABET_SIZE = 256;
    // The random part keeps the text short so that search steps stay fast.
    localparam int RAND_TEXT_CAP = 300;
    localparam int ITEMS_PER_PHASE = 27;

    logic             clk;
    logic             rst_n  = 1'b0;
    logic             start  = 1'b0;
    logic [OP_W-1:0]  op     = OP_NOP;
    logic [SYM_W-1:0] symbol = '0;
    logic             busy;
    logic             done;
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] last_row;
    logic             range_is_empty;

    int fail_count;
    int pending;

    // Stimulus bookkeeping: length of the text as loaded so far, the idle
    // setting of the current phase and a tally of what was sent.
    int unsigned      text_len    = 0;
    int unsigned      idle_pct    = 0;
    int unsigned      idle_max    = 1;
    int unsigned      n_load      = 0;
    int unsigned      n_clear     = 0;
    int unsigned      n_step      = 0;
    int unsigned      n_nop       = 0;
    logic [SYM_W-1:0] alphabet [4];

    fm_index_backward_search #(
        .MAX_TEXT      (MAX_TEXT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .symbol         (symbol),
        .done           (done),
        .first_row      (first_row),
        .last_row       (last_row),
        .range_is_empty (range_is_empty)
    );

    fm_index_backward_search_checker #(
        .MAX_TEXT      (MAX_TEXT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .symbol         (symbol),
        .done           (done),
        .first_row      (first_row),
        .last_row       (last_row),
        .range_is_empty (range_is_empty),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Upper bound on the run. The slowest correct run is some 150
    // transactions, the longest of which walk a few hundred histogram
    // entries and stored symbols, some with idle gaps between them; the
    // bound lies far above that.
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Presents one transaction and holds it until the block takes it. Busy
    // is sampled at the falling edge, so the rising edge that follows is
    // known to accept the transaction when busy was low. Start is left high
    // on return; the caller lowers it only when it goes idle.
    task automatic issue(input op_t o, input logic [SYM_W-1:0] s);
        logic was_busy;
        start  <= 1'b1;
        op     <= o;
        symbol <= s;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        case (o)
            OP_LOAD:
            begin
                n_load++;
                if (text_len < MAX_TEXT)
                    text_len++;
            end
            OP_CLEAR: n_clear++;
            OP_STEP:  n_step++;
            default:  n_nop++;
        endcase
    endtask

    // One transaction followed, with the phase's probability, by an idle gap.
    // Start is only lowered when an idle gap follows before the
    // next transaction raises it again.
    task automatic send(input op_t o, input logic [SYM_W-1:0] s);
        issue(o, s);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, idle_max))
                @(posedge clk);
        end
    endtask

    // Holds off the sender until every result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Pattern character for a search step: mostly one that is in the text,
    // sometimes anything, including the terminator.
    function automatic logic [SYM_W-1:0] pattern_char();
        if ($urandom_range(99) < 85)
            return alphabet[$urandom_range(0, 3)];
        return SYM_W'($urandom_range(0, 255));
    endfunction

    // Text symbol for a load. The terminator is loaded exactly once, in the
    // directed part, so that the last row of the index equals the stored
    // length.
    function automatic logic [SYM_W-1:0] text_char();
        if ($urandom_range(99) < 90)
            return alphabet[$urandom_range(0, 3)];
        return SYM_W'($urandom_range(1, 255));
    endfunction

    int unsigned      phase_idle [4] = '{0, 60, 0, 29};
    int unsigned      sent;
    int unsigned      kind;
    int unsigned      burst;
    op_t              noise_op;
    logic [SYM_W-1:0] noise_sym;

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back.
        // Every symbol is absent while the store is empty, the terminator
        // is never counted.
        send(OP_STEP, 8'h61);
        send(OP_STEP, 8'h00);
        // BWT of "banana$", then the extreme symbols.
        send(OP_LOAD, 8'h61);
        send(OP_LOAD, 8'h6E);
        send(OP_LOAD, 8'h6E);
        send(OP_LOAD, 8'h62);
        send(OP_LOAD, 8'h00);
        send(OP_LOAD, 8'h61);
        send(OP_LOAD, 8'h61);
        send(OP_LOAD, 8'hFF);
        send(OP_LOAD, 8'h01);
        // Backward search for "ana": a fresh range, then two narrowing steps.
        send(OP_STEP, 8'h61);
        send(OP_STEP, 8'h6E);
        send(OP_STEP, 8'h61);
        // A step that restarts from empty, then one that crosses the range.
        send(OP_STEP, 8'h62);
        send(OP_STEP, 8'h62);
        // A symbol that was never loaded empties the range.
        send(OP_STEP, 8'h7A);
        send(OP_STEP, 8'hFF);
        send(OP_STEP, 8'hFF);
        // The unused op code leaves the range as it is.
        send(OP_NOP, 8'hFF);
        send(OP_CLEAR, 8'h00);
        send(OP_STEP, 8'h01);
        send(OP_STEP, 8'h80);
        send(OP_NOP, 8'h00);
        drain();

        // Random part in four phases. The third stands for the phase in
        // which the receiver would stall; it cannot, so it runs without
        // gaps. Most traffic is well formed: runs of loads, and searches
        // that start with a clear and step through a short pattern drawn
        // from the symbols in the text. The rest is noise.
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            idle_max = 12;
            foreach (alphabet[i])
                alphabet[i] = SYM_W'($urandom_range(1, 255));
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 30 && text_len < RAND_TEXT_CAP)
                begin
                    burst = $urandom_range(1, 6);
                    repeat (burst)
                        send(OP_LOAD, text_char());
                    sent += burst;
                end
                else if (kind < 80)
                begin
                    burst = $urandom_range(1, 5);
                    send(OP_CLEAR, SYM_W'($urandom_range(0, 255)));
                    repeat (burst)
                        send(OP_STEP, pattern_char());
                    sent += burst + 1;
                end
                else
                begin
                    noise_op  = op_t'($urandom_range(0, 3));
                    noise_sym = SYM_W'($urandom_range(0, 255));
                    if (noise_op == OP_LOAD && (text_len >= RAND_TEXT_CAP || noise_sym == 0))
                        noise_op = OP_NOP;
                    send(noise_op, noise_sym);
                    sent++;
                end
            end
            // The sender waits for all results before the next phase.
            drain();
        end

        // Close with searches over the whole text loaded so far. A step with
        // the highest symbol from an empty range reaches the last row of the
        // index.
        idle_pct = 29;
        idle_max = 4;
        send(OP_CLEAR, 8'h00);
        send(OP_STEP, 8'hFF);
        send(OP_CLEAR, 8'hFF);
        repeat (3)
            send(OP_STEP, alphabet[$urandom_range(0, 3)]);
        send(OP_STEP, 8'h01);

        drain();
        // Nothing is outstanding; the wait that follows catches a stray result.
        repeat (20)
            @(posedge clk);

        $display("Covered %0d loads, %0d clears, %0d search steps",
                 n_load, n_clear, n_step);
        $display("and %0d unused-op transactions under four idle settings.", n_nop);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
